/* design/ktl_pkg.sv */
package ktl_pkg;

  localparam int unsigned NODE_COUNT = 1024;
  localparam int unsigned ALPHABET   = 26;
  localparam int unsigned SLOT_W     = $clog2(ALPHABET);
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned SYM_W      = 8;

  localparam logic [SYM_W-1:0] SYM_FIRST = 8'h61;
  localparam logic [SYM_W-1:0] SYM_LAST  = 8'h7A;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_BADSYM = 2'd2;

  typedef enum logic [1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_FULL   = 2'd1,
    FAIL_BADSYM = 2'd2,
    FAIL_MISS   = 2'd3
  } fail_e;

  typedef enum logic [1:0] {
    S_INIT  = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2,
    S_CLEAR = 2'd3
  } state_e;

endpackage

/* design/ktl_ram.sv */
module ktl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/keyword_trie_lookup.sv */
// Flow: a symbol transaction passes through accept (IDLE), then node row read-modify-write (EXEC),
// then, when it allocates a node, CLEAR, which clears the new node's row.
// An end transaction loads its result into the output register in EXEC, which follows accept;
// EXEC waits while a held result blocks the output register.
// Transactions do not overlap: a new one is accepted only in IDLE, once the last one is done.
// Reset: asynchronous; the block clears the root row in the INIT state before accepting.
// Rows of other nodes are cleared as they are allocated.
module keyword_trie_lookup #(
  parameter int unsigned NodeCount = ktl_pkg::NODE_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [ktl_pkg::SYM_W-1:0]  symbol_i,
  input  logic                       ends_key_i,
  input  logic [ktl_pkg::TYPE_W-1:0] key_type_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ktl_pkg::TYPE_W-1:0] found_type_o,
  output logic [1:0]                 status_o
);

  localparam int unsigned NodeW = $clog2(NodeCount);
  localparam int unsigned CntW  = NodeW + 1;
  localparam int unsigned LinkW = ktl_pkg::ALPHABET * NodeW;
  localparam int unsigned RowW  = LinkW + ktl_pkg::TYPE_W + 1;

  ktl_pkg::state_e state_q, state_d;
  ktl_pkg::fail_e  failed_q, failed_d;
  logic [NodeW-1:0] cur_q, cur_d;
  logic [CntW-1:0]  used_q, used_d;

  logic                       cmd_q, end_q;
  logic [ktl_pkg::SYM_W-1:0]  sym_q;
  logic [ktl_pkg::TYPE_W-1:0] ktype_q;

  logic                       out_valid_q, out_valid_d;
  logic [ktl_pkg::TYPE_W-1:0] found_q, found_d;
  logic [1:0]                 status_q, status_d;
  logic                       out_load;

  logic             ram_we, ram_re;
  logic [NodeW-1:0] ram_waddr;
  logic [RowW-1:0]  ram_wdata, row;

  logic                       in_acc, sym_ok, out_free;
  logic [ktl_pkg::SYM_W-1:0]  sym_off;
  logic [ktl_pkg::SLOT_W-1:0] slot;
  logic [NodeW-1:0]           link;
  logic [LinkW-1:0]           links_new;
  logic                       row_mark;
  logic [ktl_pkg::TYPE_W-1:0] row_type;

  ktl_ram #(
    .Width(RowW),
    .Depth(NodeCount)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_q),
    .rdata_o (row)
  );

  assign in_ready_o = (state_q == ktl_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign ram_re     = in_acc;
  assign out_free   = !out_valid_q || out_ready_i;

  assign sym_ok   = (sym_q >= ktl_pkg::SYM_FIRST) && (sym_q <= ktl_pkg::SYM_LAST);
  assign sym_off  = sym_q - ktl_pkg::SYM_FIRST;
  assign slot     = sym_off[ktl_pkg::SLOT_W-1:0];
  assign link     = row[slot*NodeW +: NodeW];
  assign row_type = row[LinkW +: ktl_pkg::TYPE_W];
  assign row_mark = row[RowW-1];

  always_comb begin
    links_new = row[LinkW-1:0];
    for (int s = 0; s < ktl_pkg::ALPHABET; s++) begin
      if (slot == ktl_pkg::SLOT_W'(s)) begin
        links_new[s*NodeW +: NodeW] = used_q[NodeW-1:0];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    failed_d  = failed_q;
    cur_d     = cur_q;
    used_d    = used_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = row;
    out_load  = 1'b0;
    found_d   = '0;
    status_d  = ktl_pkg::STATUS_OK;
    case (state_q)
      ktl_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        state_d   = ktl_pkg::S_IDLE;
      end
      ktl_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = ktl_pkg::S_EXEC;
        end
      end
      ktl_pkg::S_EXEC: begin
        if (!end_q) begin
          state_d = ktl_pkg::S_IDLE;
          if (failed_q == ktl_pkg::FAIL_NONE) begin
            if (!sym_ok) begin
              failed_d = cmd_q ? ktl_pkg::FAIL_BADSYM : ktl_pkg::FAIL_MISS;
            end else if (link != '0) begin
              cur_d = link;
            end else if (!cmd_q) begin
              failed_d = ktl_pkg::FAIL_MISS;
            end else if (used_q >= CntW'(NodeCount)) begin
              failed_d = ktl_pkg::FAIL_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {row[RowW-1:LinkW], links_new};
              cur_d     = used_q[NodeW-1:0];
              used_d    = used_q + 1'b1;
              state_d   = ktl_pkg::S_CLEAR;
            end
          end
        end else if (out_free) begin
          out_load = 1'b1;
          if (cmd_q) begin
            if (failed_q == ktl_pkg::FAIL_NONE) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, ktype_q, row[LinkW-1:0]};
            end else if (failed_q == ktl_pkg::FAIL_FULL) begin
              status_d = ktl_pkg::STATUS_FULL;
            end else begin
              status_d = ktl_pkg::STATUS_BADSYM;
            end
          end else if (failed_q == ktl_pkg::FAIL_NONE && row_mark) begin
            found_d = row_type;
          end
          cur_d    = '0;
          failed_d = ktl_pkg::FAIL_NONE;
          state_d  = ktl_pkg::S_IDLE;
        end
      end
      ktl_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        state_d   = ktl_pkg::S_IDLE;
      end
      default: begin
        state_d = ktl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ktl_pkg::S_INIT;
      failed_q    <= ktl_pkg::FAIL_NONE;
      cur_q       <= '0;
      used_q      <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      failed_q    <= failed_d;
      cur_q       <= cur_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= cmd_i;
      end_q   <= ends_key_i;
      sym_q   <= symbol_i;
      ktype_q <= key_type_i;
    end
    if (out_load) begin
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_type_o = found_q;
  assign status_o     = status_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q >= CntW'(1)) && (used_q <= CntW'(NodeCount)))
    else $error("node count out of range");

  a_cur_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(cur_q) < used_q)
    else $error("current node not allocated");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ktl_pkg::S_EXEC && end_q))
    else $error("result without end transaction");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("row read and write in same cycle");

endmodule
